// ===== hdl/adcseq_pkg.sv =====
`timescale 1ns / 1ps

package adcseq_pkg;

	// event codes on func
	localparam logic [2:0] FN_TX_READY    = 3'd0;
	localparam logic [2:0] FN_RX_BYTE     = 3'd1;
	localparam logic [2:0] FN_TX_COMPLETE = 3'd2;
	localparam logic [2:0] FN_NACK        = 3'd3;
	localparam logic [2:0] FN_START       = 3'd4;
	localparam logic [2:0] FN_READ_SUM    = 3'd5;
	localparam logic [2:0] FN_RELEASE     = 3'd6;

	// action codes on the result beat
	localparam logic [2:0] ACT_WRITE_BYTE  = 3'd0;
	localparam logic [2:0] ACT_ISSUE_STOP  = 3'd1;
	localparam logic [2:0] ACT_START_READ  = 3'd2;
	localparam logic [2:0] ACT_START_WRITE = 3'd3;
	localparam logic [2:0] ACT_SUM_REPLY   = 3'd4;

	// configuration register indexes
	localparam logic [2:0] CFG_FIRST_ADDR  = 3'd0;
	localparam logic [2:0] CFG_SECOND_ADDR = 3'd1;
	localparam logic [2:0] CFG_THIRD_ADDR  = 3'd2;
	localparam logic [2:0] CFG_OCTAL_BASE  = 3'd3;
	localparam logic [2:0] CFG_DUAL_BASE   = 3'd4;

	// device indexes
	localparam logic [1:0] DEV_FIRST  = 2'd0;
	localparam logic [1:0] DEV_SECOND = 2'd1;
	localparam logic [1:0] DEV_THIRD  = 2'd2;
	localparam logic [1:0] DEV_NONE   = 2'd3;

	localparam int OctalChannels  = 8;
	localparam int SystemChannels = 8;
	localparam int DualChannels   = 2;
	localparam int RingDepth      = 8;
	localparam int SlotBits       = 3;
	localparam int ChBits         = 3;
	localparam int DevBits        = 2;
	localparam int WordIdxBits    = DevBits + ChBits;
	localparam int LatestWords    = 24;
	localparam int RingWords      = LatestWords * RingDepth;
	localparam int RingAddrBits   = WordIdxBits + SlotBits;
	localparam int SumBits        = 19;
	localparam int DualBits       = 10;

	typedef struct packed {
		logic latch;
		logic exec;
		logic copy_step;
		logic sum_init;
		logic sum_step;
		logic sum_load;
	} cmd_t;

	typedef struct packed {
		logic is_sum;
		logic has_result;
		logic copy_needed;
		logic copy_last;
		logic sum_last;
	} sts_t;

	// channel count of a device; zero for the unused index
	function automatic logic [3:0] ch_count(input logic [1:0] dev);
		logic [3:0] n;
		unique case (dev)
			DEV_FIRST:  n = 4'(OctalChannels);
			DEV_SECOND: n = 4'(SystemChannels);
			DEV_THIRD:  n = 4'(DualChannels);
			default:    n = 4'd0;
		endcase
		return n;
	endfunction

	// channel-select command byte, per device type
	function automatic logic [7:0] build_cmd(input logic [1:0] dev, input logic [2:0] ch,
		input logic [7:0] obase, input logic [7:0] dbase);
		logic [2:0] t;
		t = {ch[0], ch[2:1]};
		if (dev == DEV_THIRD)
			return dbase | {4'd0, ch, 1'b0};
		return obase | {1'b0, t, 4'd0};
	endfunction

endpackage

// ===== hdl/adcseq_ctrl.sv =====
`timescale 1ns / 1ps

module adcseq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  adcseq_pkg::sts_t    sts,
	output adcseq_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_COPY, S_SUM, S_SUM_FIN, S_SUM_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// commands to the datapath
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:    cmd.latch = in_valid;
			S_EXEC: begin
				cmd.sum_init = sts.is_sum;
				cmd.exec     = !sts.is_sum && out_free;
			end
			S_COPY:    cmd.copy_step = 1'b1;
			S_SUM:     cmd.sum_step = 1'b1;
			S_SUM_FIN: ;
			S_SUM_OUT: cmd.sum_load = out_free;
			default:   ;
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (out_valid_q && !out_ready) || (cmd.exec && sts.has_result)
				|| cmd.sum_load;
			unique case (state_q)
				S_IDLE:    if (in_valid) state_q <= S_EXEC;
				S_EXEC: begin
					if (sts.is_sum)
						state_q <= S_SUM;
					else if (out_free)
						state_q <= sts.copy_needed ? S_COPY : S_IDLE;
				end
				S_COPY:    if (sts.copy_last) state_q <= S_IDLE;
				S_SUM:     if (sts.sum_last) state_q <= S_SUM_FIN;
				S_SUM_FIN: state_q <= S_SUM_OUT;
				S_SUM_OUT: if (out_free) state_q <= S_IDLE;
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.exec, cmd.copy_step, cmd.sum_init, cmd.sum_step, cmd.sum_load}))
		else $error("more than one datapath command");
	a_copy_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COPY) && !$past(state_q == S_COPY) |-> $past(cmd.exec))
		else $error("copy entered without exec");
	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q)
		else $error("result dropped");

endmodule

// ===== hdl/adcseq_dp.sv =====
`timescale 1ns / 1ps

module adcseq_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	input  logic [2:0]          func,
	input  logic [7:0]          rx_data,
	input  logic [1:0]          device_sel,
	input  logic [2:0]          channel_sel,
	input  adcseq_pkg::cmd_t    cmd,
	output adcseq_pkg::sts_t    sts,
	output logic [2:0]          action,
	output logic [6:0]          bus_addr,
	output logic [7:0]          tx_byte,
	output logic                nack_fault,
	output logic [18:0]         sample_sum,
	output logic                snapshot_ready
);

	// configuration
	logic [6:0] addr0_q, addr1_q, addr2_q;
	logic [7:0] obase_q, dbase_q;

	// latched item
	logic [2:0] fn_q;
	logic [7:0] data_q;
	logic [1:0] dsel_q;
	logic [2:0] csel_q;

	// scan state
	logic [1:0] dev_q;
	logic [2:0] ch_q;
	logic       wp_q, tx_q, held_q;
	logic [1:0] rx_q;
	logic [7:0] cmdb_q;
	logic [adcseq_pkg::SlotBits-1:0] ring_idx_q;
	logic [adcseq_pkg::RingDepth-1:0] slot_valid_q;
	logic [15:0] latest_q [adcseq_pkg::LatestWords];
	logic [15:0] ring_mem [adcseq_pkg::RingWords];

	// sweep and sum
	logic [adcseq_pkg::WordIdxBits-1:0] step_q;
	logic [15:0] rd_s1;
	logic        en_s1, slotv_s1;
	logic [adcseq_pkg::SumBits-1:0] acc_q;

	// next-state helpers
	logic       wrap, advance, copy_needed, rx_store, query_ok;
	logic [1:0] nxt_dev, nrx;
	logic [2:0] nxt_ch;
	logic [7:0] nxt_cmd, start_cmd;
	logic [6:0] cur_addr, nxt_addr;
	logic [adcseq_pkg::SlotBits-1:0] ring_nxt;
	logic [2:0] act_d;
	logic [6:0] addr_d;
	logic [7:0] byte_d;
	logic       nf_d, has_res;
	logic [15:0] masked;

	function automatic logic [6:0] dev_addr(input logic [1:0] d, input logic [6:0] a0,
		input logic [6:0] a1, input logic [6:0] a2);
		logic [6:0] r;
		unique case (d)
			adcseq_pkg::DEV_SECOND: r = a1;
			adcseq_pkg::DEV_THIRD:  r = a2;
			default:                r = a0;
		endcase
		return r;
	endfunction

	// channel advance
	always_comb begin
		wrap     = (fn_q == adcseq_pkg::FN_NACK) ||
			(({1'b0, ch_q} + 4'd1) >= adcseq_pkg::ch_count(dev_q));
		nxt_ch   = wrap ? 3'd0 : ch_q + 3'd1;
		nxt_dev  = !wrap ? dev_q : ((dev_q >= adcseq_pkg::DEV_THIRD) ? adcseq_pkg::DEV_FIRST
			: dev_q + 2'd1);
		advance  = (fn_q == adcseq_pkg::FN_NACK) ||
			((fn_q == adcseq_pkg::FN_TX_COMPLETE) && !wp_q);
		copy_needed = advance && wrap && (dev_q == adcseq_pkg::DEV_THIRD) && !held_q;
		nxt_cmd  = adcseq_pkg::build_cmd(nxt_dev, nxt_ch, obase_q, dbase_q);
		start_cmd = adcseq_pkg::build_cmd(adcseq_pkg::DEV_FIRST, 3'd0, obase_q, dbase_q);
		cur_addr = dev_addr(dev_q, addr0_q, addr1_q, addr2_q);
		nxt_addr = dev_addr(nxt_dev, addr0_q, addr1_q, addr2_q);
		ring_nxt = ring_idx_q + adcseq_pkg::SlotBits'(1);
		nrx      = rx_q + 2'd1;
		rx_store = (rx_q < 2'd2) && (dev_q != adcseq_pkg::DEV_NONE) &&
			({1'b0, ch_q} < adcseq_pkg::ch_count(dev_q));
		query_ok = (dsel_q != adcseq_pkg::DEV_NONE) &&
			({1'b0, csel_q} < adcseq_pkg::ch_count(dsel_q));
		masked   = (dsel_q == adcseq_pkg::DEV_THIRD) ?
			{6'd0, rd_s1[adcseq_pkg::DualBits-1:0]} : rd_s1;
	end

	// result of a bus event
	always_comb begin
		act_d   = adcseq_pkg::ACT_ISSUE_STOP;
		addr_d  = 7'd0;
		byte_d  = 8'd0;
		nf_d    = 1'b0;
		has_res = 1'b0;
		case (fn_q)
			adcseq_pkg::FN_TX_READY: begin
				has_res = 1'b1;
				if (!tx_q) begin
					act_d  = adcseq_pkg::ACT_WRITE_BYTE;
					byte_d = cmdb_q;
				end
			end
			adcseq_pkg::FN_RX_BYTE: has_res = (nrx == 2'd1);
			adcseq_pkg::FN_TX_COMPLETE, adcseq_pkg::FN_NACK: begin
				has_res = 1'b1;
				if (!advance) begin
					act_d  = adcseq_pkg::ACT_START_READ;
					addr_d = cur_addr;
				end else begin
					act_d  = adcseq_pkg::ACT_START_WRITE;
					addr_d = nxt_addr;
					byte_d = nxt_cmd;
					nf_d   = (fn_q == adcseq_pkg::FN_NACK);
				end
			end
			adcseq_pkg::FN_START: begin
				has_res = 1'b1;
				act_d   = adcseq_pkg::ACT_START_WRITE;
				addr_d  = addr0_q;
				byte_d  = start_cmd;
			end
			default: ;
		endcase
	end

	assign sts.is_sum      = (fn_q == adcseq_pkg::FN_READ_SUM);
	assign sts.has_result  = has_res;
	assign sts.copy_needed = copy_needed;
	assign sts.copy_last   = (step_q == adcseq_pkg::WordIdxBits'(adcseq_pkg::LatestWords - 1));
	assign sts.sum_last    = (step_q[adcseq_pkg::SlotBits-1:0] ==
		adcseq_pkg::SlotBits'(adcseq_pkg::RingDepth - 1));

	// config, item latch and scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr0_q      <= 7'd72;
			addr1_q      <= 7'd73;
			addr2_q      <= 7'd54;
			obase_q      <= 8'd132;
			dbase_q      <= 8'd97;
			fn_q         <= adcseq_pkg::FN_TX_READY;
			data_q       <= 8'd0;
			dsel_q       <= 2'd0;
			csel_q       <= 3'd0;
			dev_q        <= adcseq_pkg::DEV_FIRST;
			ch_q         <= 3'd0;
			wp_q         <= 1'b1;
			tx_q         <= 1'b0;
			rx_q         <= 2'd0;
			cmdb_q       <= 8'd0;
			held_q       <= 1'b0;
			ring_idx_q   <= '0;
			slot_valid_q <= '0;
			step_q       <= '0;
			en_s1        <= 1'b0;
			slotv_s1     <= 1'b0;
			acc_q        <= '0;
			for (int i = 0; i < adcseq_pkg::LatestWords; i++)
				latest_q[i] <= 16'd0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					adcseq_pkg::CFG_FIRST_ADDR:  addr0_q <= cfg_data[6:0];
					adcseq_pkg::CFG_SECOND_ADDR: addr1_q <= cfg_data[6:0];
					adcseq_pkg::CFG_THIRD_ADDR:  addr2_q <= cfg_data[6:0];
					adcseq_pkg::CFG_OCTAL_BASE:  obase_q <= cfg_data;
					adcseq_pkg::CFG_DUAL_BASE:   dbase_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.latch) begin
				fn_q   <= func;
				data_q <= rx_data;
				dsel_q <= device_sel;
				csel_q <= channel_sel;
			end
			if (cmd.exec) begin
				case (fn_q)
					adcseq_pkg::FN_TX_READY: tx_q <= !tx_q;
					adcseq_pkg::FN_RX_BYTE: begin
						if (rx_store) begin
							if (rx_q == 2'd0)
								latest_q[{dev_q, ch_q}] <= {data_q, 8'd0};
							else
								latest_q[{dev_q, ch_q}] <= latest_q[{dev_q, ch_q}] | {8'd0, data_q};
						end
						rx_q <= (nrx >= 2'd2) ? 2'd0 : nrx;
					end
					adcseq_pkg::FN_TX_COMPLETE, adcseq_pkg::FN_NACK: begin
						if (!advance) begin
							wp_q <= 1'b0;
						end else begin
							dev_q  <= nxt_dev;
							ch_q   <= nxt_ch;
							rx_q   <= 2'd0;
							tx_q   <= 1'b0;
							wp_q   <= 1'b1;
							cmdb_q <= nxt_cmd;
							if (copy_needed) begin
								ring_idx_q             <= ring_nxt;
								slot_valid_q[ring_nxt] <= 1'b1;
								held_q                 <= 1'b1;
							end
						end
					end
					adcseq_pkg::FN_START: begin
						dev_q  <= adcseq_pkg::DEV_FIRST;
						ch_q   <= 3'd0;
						rx_q   <= 2'd0;
						tx_q   <= 1'b0;
						wp_q   <= 1'b1;
						held_q <= 1'b0;
						cmdb_q <= start_cmd;
					end
					adcseq_pkg::FN_RELEASE: held_q <= 1'b0;
					default: ;
				endcase
			end
			// shared sweep counter
			if (cmd.exec || cmd.sum_init)
				step_q <= '0;
			else if (cmd.copy_step || cmd.sum_step)
				step_q <= step_q + 1'b1;
			// accumulate one ring slot per cycle
			en_s1    <= cmd.sum_step && query_ok;
			slotv_s1 <= slot_valid_q[step_q[adcseq_pkg::SlotBits-1:0]];
			if (cmd.sum_init)
				acc_q <= '0;
			else if (en_s1 && slotv_s1)
				acc_q <= acc_q + adcseq_pkg::SumBits'(masked);
		end
	end

	// sample ring: one write port for the copy, one read port for the sum
	always_ff @(posedge clk) begin
		if (cmd.copy_step)
			ring_mem[{step_q, ring_idx_q}] <= latest_q[step_q];
		if (cmd.sum_step && query_ok)
			rd_s1 <= ring_mem[{dsel_q, csel_q, step_q[adcseq_pkg::SlotBits-1:0]}];
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec && has_res) begin
			action         <= act_d;
			bus_addr       <= addr_d;
			tx_byte        <= byte_d;
			nack_fault     <= nf_d;
			sample_sum     <= '0;
			snapshot_ready <= 1'b0;
		end else if (cmd.sum_load) begin
			action         <= adcseq_pkg::ACT_SUM_REPLY;
			bus_addr       <= 7'd0;
			tx_byte        <= 8'd0;
			nack_fault     <= 1'b0;
			sample_sum     <= acc_q;
			snapshot_ready <= held_q;
		end
	end

	a_dev_valid: assert property (@(posedge clk) disable iff (!arst_n)
		dev_q != adcseq_pkg::DEV_NONE)
		else $error("scan device out of range");
	a_ch_valid: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, ch_q} < adcseq_pkg::ch_count(dev_q))
		else $error("scan channel out of range");
	a_rx_count: assert property (@(posedge clk) disable iff (!arst_n)
		rx_q < 2'd2)
		else $error("rx count out of range");
	a_copy_held: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.copy_step |-> held_q && slot_valid_q[ring_idx_q])
		else $error("copy without held snapshot");

endmodule

// ===== hdl/i2c_adc_scan_sequencer.sv =====
`timescale 1ns / 1ps

// Channel   | Handshake              | Beat contents
// ----------+------------------------+-------------------------------------------
// in        | in_valid / in_ready    | func, rx_data, device_sel, channel_sel
// out       | out_valid / out_ready  | action, bus_addr, tx_byte, nack_fault,
//           |                        | sample_sum, snapshot_ready
// cfg       | cfg_we (no wait)       | cfg_index, cfg_data
//
// A bus event is latched, then executed once the output register is free.
// Leaving the last device with no snapshot held adds a copy of 24 words, one word
// a cycle through the single ring write port. A sum query reads eight ring slots
// one a cycle, after latch and setup, then drains and loads the result.
// Reset clears all scan state, the latest words and the ring slot valid bits.
// A new beat is accepted while a finished result still waits in the output register.

module i2c_adc_scan_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [7:0]  rx_data,
	input  logic [1:0]  device_sel,
	input  logic [2:0]  channel_sel,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  action,
	output logic [6:0]  bus_addr,
	output logic [7:0]  tx_byte,
	output logic        nack_fault,
	output logic [18:0] sample_sum,
	output logic        snapshot_ready
);

	adcseq_pkg::cmd_t cmd;
	adcseq_pkg::sts_t sts;

	adcseq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	adcseq_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.func           (func),
		.rx_data        (rx_data),
		.device_sel     (device_sel),
		.channel_sel    (channel_sel),
		.cmd            (cmd),
		.sts            (sts),
		.action         (action),
		.bus_addr       (bus_addr),
		.tx_byte        (tx_byte),
		.nack_fault     (nack_fault),
		.sample_sum     (sample_sum),
		.snapshot_ready (snapshot_ready)
	);

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

	typedef struct packed {
		logic [2:0]  action;
		logic [6:0]  bus_addr;
		logic [7:0]  tx_byte;
		logic        nack_fault;
		logic [18:0] sample_sum;
		logic        snapshot_ready;
	} bus_beat_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  func;
	logic [7:0]  rx_data;
	logic [1:0]  device_sel;
	logic [2:0]  channel_sel;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  action;
	logic [6:0]  bus_addr;
	logic [7:0]  tx_byte;
	logic        nack_fault;
	logic [18:0] sample_sum;
	logic        snapshot_ready;

	i2c_adc_scan_sequencer i_dut (.*);

	// scanner shadow state
	logic [6:0]  sh_addr [3];
	logic [7:0]  sh_octal_base, sh_dual_base;
	logic [1:0]  sh_dev;
	logic [2:0]  sh_ch;
	logic        sh_write_phase, sh_tx_cnt, sh_held;
	logic [1:0]  sh_rx_cnt;
	logic [7:0]  sh_cmd;
	logic [2:0]  sh_slot;
	logic [15:0] sh_latest [3][8];
	logic [15:0] sh_ring [3][8][8];

	bus_beat_t pending_beats [$];
	int fails = 0;
	int items_sent = 0;
	int beats_checked = 0;
	int copies_seen = 0;
	bit quiet_in = 0;
	bit quiet_out = 0;

	// clock
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int chan_count(input logic [1:0] dev);
		if (dev == adcseq_pkg::DEV_THIRD) return adcseq_pkg::DualChannels;
		if (dev == adcseq_pkg::DEV_NONE) return 0;
		return adcseq_pkg::OctalChannels;
	endfunction

	function automatic void make_cmd();
		logic [2:0] t;
		t = sh_ch[0] ? 3'((sh_ch + 7) / 2) : 3'(sh_ch / 2);
		if (sh_dev == adcseq_pkg::DEV_THIRD) sh_cmd = sh_dual_base | {4'd0, sh_ch, 1'b0};
		else sh_cmd = sh_octal_base | {1'b0, t, 4'd0};
	endfunction

	function automatic void advance_channel(input int ch);
		sh_rx_cnt = 0;
		sh_tx_cnt = 0;
		sh_write_phase = 1;
		ch++;
		if (ch >= chan_count(sh_dev)) begin
			ch = 0;
			if (sh_dev == adcseq_pkg::DEV_FIRST) sh_dev = adcseq_pkg::DEV_SECOND;
			else if (sh_dev == adcseq_pkg::DEV_SECOND) sh_dev = adcseq_pkg::DEV_THIRD;
			else begin
				// wrap: snapshot unless one is held
				if (!sh_held) begin
					sh_slot = sh_slot + 1;
					for (int d = 0; d < 3; d++)
						for (int c = 0; c < 8; c++)
							sh_ring[d][c][sh_slot] = sh_latest[d][c];
					sh_held = 1;
					copies_seen++;
				end
				sh_dev = adcseq_pkg::DEV_FIRST;
			end
		end
		sh_ch = 3'(ch);
		make_cmd();
	endfunction

	// next bus action for one accepted event
	function automatic bit scan_step(input logic [2:0] f, input logic [7:0] d,
		input logic [1:0] ds, input logic [2:0] cs, output bus_beat_t b);
		logic [18:0] sum;
		b = '0;
		case (f)
			adcseq_pkg::FN_TX_READY: begin
				if (!sh_tx_cnt) begin
					sh_tx_cnt = 1;
					b.action = adcseq_pkg::ACT_WRITE_BYTE;
					b.tx_byte = sh_cmd;
				end else begin
					sh_tx_cnt = 0;
					b.action = adcseq_pkg::ACT_ISSUE_STOP;
				end
				return 1;
			end
			adcseq_pkg::FN_RX_BYTE: begin
				if (sh_rx_cnt == 0) sh_latest[sh_dev][sh_ch] = {d, 8'h00};
				else sh_latest[sh_dev][sh_ch] = sh_latest[sh_dev][sh_ch] | {8'h00, d};
				sh_rx_cnt = sh_rx_cnt + 1;
				if (sh_rx_cnt == 1) begin
					b.action = adcseq_pkg::ACT_ISSUE_STOP;
					return 1;
				end
				sh_rx_cnt = 0;
				return 0;
			end
			adcseq_pkg::FN_TX_COMPLETE: begin
				if (sh_write_phase) begin
					sh_write_phase = 0;
					b.action = adcseq_pkg::ACT_START_READ;
					b.bus_addr = sh_addr[sh_dev];
				end else begin
					advance_channel(sh_ch);
					b.action = adcseq_pkg::ACT_START_WRITE;
					b.bus_addr = sh_addr[sh_dev];
					b.tx_byte = sh_cmd;
				end
				return 1;
			end
			adcseq_pkg::FN_NACK: begin
				advance_channel(100);
				b.action = adcseq_pkg::ACT_START_WRITE;
				b.bus_addr = sh_addr[sh_dev];
				b.tx_byte = sh_cmd;
				b.nack_fault = 1;
				return 1;
			end
			adcseq_pkg::FN_START: begin
				sh_dev = adcseq_pkg::DEV_FIRST;
				sh_ch = 0;
				sh_rx_cnt = 0;
				sh_tx_cnt = 0;
				sh_write_phase = 1;
				sh_held = 0;
				make_cmd();
				b.action = adcseq_pkg::ACT_START_WRITE;
				b.bus_addr = sh_addr[0];
				b.tx_byte = sh_cmd;
				return 1;
			end
			adcseq_pkg::FN_READ_SUM: begin
				sum = 0;
				if (ds != adcseq_pkg::DEV_NONE && cs < chan_count(ds))
					for (int i = 0; i < 8; i++)
						sum += (ds == adcseq_pkg::DEV_THIRD) ? 19'(sh_ring[ds][cs][i][9:0])
							: 19'(sh_ring[ds][cs][i]);
				b.action = adcseq_pkg::ACT_SUM_REPLY;
				b.sample_sum = sum;
				b.snapshot_ready = sh_held;
				return 1;
			end
			adcseq_pkg::FN_RELEASE: begin
				sh_held = 0;
				return 0;
			end
			default: return 0;
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// send one event beat and record what it should cause
	task automatic send_event(input logic [2:0] f, input logic [7:0] d,
		input logic [1:0] ds, input logic [2:0] cs);
		int gap;
		bit rdy;
		bus_beat_t b;
		gap = quiet_in ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		func <= f;
		rx_data <= d;
		device_sel <= ds;
		channel_sel <= cs;
		do begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end while (!rdy);
		if (scan_step(f, d, ds, cs, b)) pending_beats.push_back(b);
		items_sent++;
	endtask

	// stop sending and let every expected beat and any copy finish
	task automatic drain();
		in_valid <= 0;
		wait (pending_beats.size() == 0);
		repeat (60) @(posedge clk);
	endtask

	task automatic load_config(input logic [6:0] a0, input logic [6:0] a1,
		input logic [6:0] a2, input logic [7:0] ob, input logic [7:0] db);
		logic [7:0] vals [5];
		vals = '{{1'b0, a0}, {1'b0, a1}, {1'b0, a2}, ob, db};
		drain();
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1;
			cfg_index <= 3'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 0;
		sh_addr[0] = a0;
		sh_addr[1] = a1;
		sh_addr[2] = a2;
		sh_octal_base = ob;
		sh_dual_base = db;
	endtask

	// one well-formed channel visit: command, read, move on
	task automatic visit_channel();
		send_event(adcseq_pkg::FN_TX_READY, 8'($urandom), 2'($urandom), 3'($urandom));
		send_event(adcseq_pkg::FN_TX_READY, 8'($urandom), 2'($urandom), 3'($urandom));
		send_event(adcseq_pkg::FN_TX_COMPLETE, 8'($urandom), 2'($urandom), 3'($urandom));
		send_event(adcseq_pkg::FN_RX_BYTE, 8'($urandom), 2'($urandom), 3'($urandom));
		send_event(adcseq_pkg::FN_RX_BYTE, 8'($urandom), 2'($urandom), 3'($urandom));
		send_event(adcseq_pkg::FN_TX_COMPLETE, 8'($urandom), 2'($urandom), 3'($urandom));
	endtask

	task automatic test_directed();
		send_event(adcseq_pkg::FN_READ_SUM, 8'h00, adcseq_pkg::DEV_FIRST, 3'd0);
		send_event(adcseq_pkg::FN_START, 8'h00, 2'd0, 3'd0);
		send_event(adcseq_pkg::FN_TX_READY, 8'h00, 2'd0, 3'd0);
		send_event(adcseq_pkg::FN_TX_READY, 8'h00, 2'd0, 3'd0);
		send_event(adcseq_pkg::FN_TX_COMPLETE, 8'h00, 2'd0, 3'd0);
		send_event(adcseq_pkg::FN_RX_BYTE, 8'hFF, 2'd0, 3'd0);
		send_event(adcseq_pkg::FN_RX_BYTE, 8'hFF, 2'd0, 3'd0);
		send_event(adcseq_pkg::FN_TX_COMPLETE, 8'h00, 2'd0, 3'd0);
		// byte arriving during the write phase is still stored
		send_event(adcseq_pkg::FN_RX_BYTE, 8'h00, 2'd0, 3'd0);
		send_event(adcseq_pkg::FN_RX_BYTE, 8'hA5, 2'd0, 3'd0);
		// fault skips straight to the next device, twice, then wraps
		send_event(adcseq_pkg::FN_NACK, 8'h00, 2'd0, 3'd0);
		send_event(adcseq_pkg::FN_NACK, 8'h00, 2'd0, 3'd0);
		send_event(adcseq_pkg::FN_NACK, 8'h00, 2'd0, 3'd0);
		send_event(adcseq_pkg::FN_READ_SUM, 8'h00, adcseq_pkg::DEV_FIRST, 3'd0);
		send_event(adcseq_pkg::FN_READ_SUM, 8'h00, adcseq_pkg::DEV_FIRST, 3'd1);
		send_event(adcseq_pkg::FN_READ_SUM, 8'h00, adcseq_pkg::DEV_THIRD, 3'd7);
		send_event(adcseq_pkg::FN_READ_SUM, 8'h00, adcseq_pkg::DEV_NONE, 3'd0);
		// wrap while held loses the sample
		send_event(adcseq_pkg::FN_NACK, 8'h00, 2'd0, 3'd0);
		send_event(adcseq_pkg::FN_NACK, 8'h00, 2'd0, 3'd0);
		send_event(adcseq_pkg::FN_NACK, 8'h00, 2'd0, 3'd0);
		send_event(adcseq_pkg::FN_RELEASE, 8'h00, 2'd0, 3'd0);
		send_event(3'd7, 8'hFF, 2'd3, 3'd7);
		send_event(adcseq_pkg::FN_READ_SUM, 8'h00, adcseq_pkg::DEV_SECOND, 3'd7);
	endtask

	// mostly clean scans with random data, with faults, queries and noise mixed in
	task automatic test_random_scan(input int quota);
		int stop_at, r;
		stop_at = items_sent + quota;
		while (items_sent < stop_at) begin
			r = $urandom_range(0, 99);
			quiet_in = ($urandom_range(0, 9) == 0);
			if (r < 62) visit_channel();
			else if (r < 67) send_event(adcseq_pkg::FN_NACK, 8'($urandom), 2'($urandom),
				3'($urandom));
			else if (r < 80) send_event(adcseq_pkg::FN_READ_SUM, 8'($urandom), 2'($urandom),
				3'($urandom));
			else if (r < 86) send_event(adcseq_pkg::FN_RELEASE, 8'($urandom), 2'($urandom),
				3'($urandom));
			else if (r < 88) send_event(adcseq_pkg::FN_START, 8'($urandom), 2'($urandom),
				3'($urandom));
			else send_event(3'($urandom), 8'($urandom), 2'($urandom), 3'($urandom));
		end
		quiet_in = 0;
	endtask

	task automatic test_backpressure_pause();
		visit_channel();
		in_valid <= 0;
		wait (pending_beats.size() == 0);
		@(posedge clk);
		visit_channel();
	endtask

	// sink side: random stalls
	initial begin
		out_ready = 0;
		forever begin
			@(posedge clk);
			if (quiet_out || $urandom_range(0, 2) != 0) out_ready <= 1;
			else begin
				out_ready <= 0;
				repeat (pick_gap()) @(posedge clk);
			end
			quiet_out = ($urandom_range(0, 199) == 0) ? ~quiet_out : quiet_out;
		end
	end

	// result checker
	initial begin
		bit hit;
		bus_beat_t got, exp_b;
		forever begin
			@(negedge clk);
			hit = out_valid && out_ready;
			got = '{action, bus_addr, tx_byte, nack_fault, sample_sum, snapshot_ready};
			@(posedge clk);
			if (hit) begin
				if (pending_beats.size() == 0) begin
					$error("unexpected result beat, action %0d", got.action);
					fails++;
				end else begin
					exp_b = pending_beats.pop_front();
					beats_checked++;
					if (got.action !== exp_b.action) begin
						$error("action: expected %0d, got %0d", exp_b.action, got.action);
						fails++;
					end
					if (got.bus_addr !== exp_b.bus_addr) begin
						$error("bus_addr: expected %0d, got %0d", exp_b.bus_addr,
							got.bus_addr);
						fails++;
					end
					if (got.tx_byte !== exp_b.tx_byte) begin
						$error("tx_byte: expected %0h, got %0h", exp_b.tx_byte, got.tx_byte);
						fails++;
					end
					if (got.nack_fault !== exp_b.nack_fault) begin
						$error("nack_fault: expected %0d, got %0d", exp_b.nack_fault,
							got.nack_fault);
						fails++;
					end
					if (got.sample_sum !== exp_b.sample_sum) begin
						$error("sample_sum: expected %0d, got %0d", exp_b.sample_sum,
							got.sample_sum);
						fails++;
					end
					if (got.snapshot_ready !== exp_b.snapshot_ready) begin
						$error("snapshot_ready: expected %0d, got %0d",
							exp_b.snapshot_ready, got.snapshot_ready);
						fails++;
					end
				end
			end
		end
	end

	// main sequence
	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		in_valid = 0;
		func = 0;
		rx_data = 0;
		device_sel = 0;
		channel_sel = 0;
		sh_addr = '{7'd72, 7'd73, 7'd54};
		sh_octal_base = 8'd132;
		sh_dual_base = 8'd97;
		sh_dev = adcseq_pkg::DEV_FIRST;
		sh_ch = 0;
		sh_write_phase = 1;
		sh_tx_cnt = 0;
		sh_rx_cnt = 0;
		sh_cmd = 0;
		sh_held = 0;
		sh_slot = 0;
		for (int d = 0; d < 3; d++)
			for (int c = 0; c < 8; c++) begin
				sh_latest[d][c] = 0;
				for (int s = 0; s < 8; s++) sh_ring[d][c][s] = 0;
			end
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		test_directed();
		test_random_scan(300);
		test_backpressure_pause();
		load_config(7'd0, 7'd0, 7'd0, 8'h00, 8'h00);
		test_random_scan(350);
		load_config(7'h7F, 7'h7F, 7'h7F, 8'hFF, 8'hFF);
		test_random_scan(300);
		load_config(7'($urandom), 7'($urandom), 7'($urandom), 8'($urandom), 8'($urandom));
		test_random_scan(350);
		load_config(7'h55, 7'h2A, 7'h01, 8'h0F, 8'h80);
		test_random_scan(320);

		drain();
		$display("covered %0d event beats, %0d result beats, %0d ring snapshots",
			items_sent, beats_checked, copies_seen);
		$display("five register settings including all-zero and all-ones");
		if (fails == 0 && pending_beats.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/adcseq_pkg.sv
hdl/adcseq_ctrl.sv
hdl/adcseq_dp.sv
hdl/i2c_adc_scan_sequencer.sv
dv/tb.sv
